// ----- rtl/dpp_pkg.sv -----
// Shared constants, types and register codes of the diagonal pixel predictor.
package dpp_pkg;

    localparam int MAX_WIDTH      = 4096;
    localparam int SAMPLE_BITS    = 16;
    localparam int COL_BITS       = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS     = 13;
    localparam int HEIGHT_BITS    = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic DIR_FORWARD = 1'b0;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [COL_BITS-1:0]    col_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_DIRECTION    = 2'd0,
        REG_FRAME_WIDTH  = 2'd1,
        REG_FRAME_HEIGHT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        col_t col;
        logic first_row;
        logic first_col;
        logic last;
    } raster_pos_t;

endpackage

// ----- rtl/dpp_line_store.sv -----
// Line store RAM holding the previous row, with bypass of a same-cycle write.
module dpp_line_store (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  dpp_pkg::col_t    rd_addr,
    output dpp_pkg::sample_t rd_data,
    input  logic             wr_en,
    input  dpp_pkg::col_t    wr_addr,
    input  dpp_pkg::sample_t wr_data
);

    dpp_pkg::sample_t mem [dpp_pkg::MAX_WIDTH];
    dpp_pkg::sample_t rd_q_reg;
    dpp_pkg::sample_t bypass_data_reg;
    logic             bypass_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // A write to the address being read in the same cycle wins over the array.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            bypass_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            bypass_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = bypass_reg ? bypass_data_reg : rd_q_reg;

endmodule

// ----- rtl/dpp_raster_ctrl.sv -----
// Column and row counters that track the raster position within a frame.
module dpp_raster_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  logic [dpp_pkg::WIDTH_BITS-1:0]   frame_width,
    input  logic [dpp_pkg::HEIGHT_BITS-1:0]  frame_height,
    output dpp_pkg::raster_pos_t             pos
);

    localparam int CMP_BITS = (dpp_pkg::COL_BITS + 1 > dpp_pkg::WIDTH_BITS) ?
                              dpp_pkg::COL_BITS + 1 : dpp_pkg::WIDTH_BITS;
    localparam int ROW_CMP_BITS = dpp_pkg::HEIGHT_BITS + 1;

    dpp_pkg::col_t                  col_reg;
    dpp_pkg::col_t                  col_next;
    logic [dpp_pkg::HEIGHT_BITS-1:0] row_reg;
    logic [dpp_pkg::HEIGHT_BITS-1:0] row_next;

    logic [CMP_BITS-1:0]     width_ext;
    logic [CMP_BITS-1:0]     eff_width;
    logic [CMP_BITS-1:0]     col_plus;
    logic [ROW_CMP_BITS-1:0] eff_height;
    logic [ROW_CMP_BITS-1:0] row_plus;
    logic                    last_col;
    logic                    last_row;

    always_comb
    begin
        width_ext = CMP_BITS'(frame_width);
        if (width_ext == '0)
        begin
            eff_width = CMP_BITS'(1);
        end
        else if (width_ext > CMP_BITS'(dpp_pkg::MAX_WIDTH))
        begin
            eff_width = CMP_BITS'(dpp_pkg::MAX_WIDTH);
        end
        else
        begin
            eff_width = width_ext;
        end
        eff_height = (frame_height == '0) ? ROW_CMP_BITS'(1) : ROW_CMP_BITS'(frame_height);
        col_plus   = CMP_BITS'(col_reg) + CMP_BITS'(1);
        row_plus   = ROW_CMP_BITS'(row_reg) + ROW_CMP_BITS'(1);
        last_col   = col_plus >= eff_width;
        last_row   = row_plus >= eff_height;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_plus[dpp_pkg::HEIGHT_BITS-1:0];
            end
            else
            begin
                col_next = col_plus[dpp_pkg::COL_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign pos.col       = col_reg;
    assign pos.first_row = (row_reg == '0);
    assign pos.first_col = (col_reg == '0);
    assign pos.last      = last_col && last_row;

    a_wrap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && pos.last |=> col_reg == '0 && row_reg == '0)
        else $error("Raster position did not wrap after the last pixel.");

    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !last_col |=> col_reg == dpp_pkg::COL_BITS'($past(col_reg) + 1'b1))
        else $error("Column counter did not step by one.");

endmodule

// ----- rtl/diagonal_pixel_predictor.sv -----
// Top level of the diagonal pixel predictor: config registers, compute stage, output.
// Datapath: an accepted request is registered in the compute stage, and its result is
// then registered in the output register, which holds it until out_ready takes it.
// Throughput: one request per cycle unless a stalled output holds the compute stage, set by
// one line store read at acceptance and one write as the request leaves the compute stage.
// Reset clears counters, neighbor registers and valids; the line store is not cleared.
module diagonal_pixel_predictor (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dpp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [dpp_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [dpp_pkg::SAMPLE_BITS-1:0] sample_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [dpp_pkg::SAMPLE_BITS-1:0] result_value,
    output logic                                frame_last
);

    logic                             direction_reg;
    logic [dpp_pkg::WIDTH_BITS-1:0]   frame_width_reg;
    logic [dpp_pkg::HEIGHT_BITS-1:0]  frame_height_reg;

    logic                 s1_valid_reg;
    dpp_pkg::sample_t     s1_sample_reg;
    dpp_pkg::raster_pos_t s1_pos_reg;
    logic                 out_valid_reg;
    dpp_pkg::sample_t     result_reg;
    logic                 last_reg;
    dpp_pkg::sample_t     left_reg;
    dpp_pkg::sample_t     above_left_reg;

    dpp_pkg::raster_pos_t pos;
    dpp_pkg::sample_t     above_data;
    dpp_pkg::sample_t     pred;
    dpp_pkg::sample_t     pixel;
    dpp_pkg::sample_t     result;
    logic                 in_accept;
    logic                 s1_advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg    <= dpp_pkg::DIR_FORWARD;
            frame_width_reg  <= dpp_pkg::WIDTH_BITS'(4096);
            frame_height_reg <= dpp_pkg::HEIGHT_BITS'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (dpp_pkg::cfg_reg_t'(cfg_index))
                dpp_pkg::REG_DIRECTION:    direction_reg    <= cfg_data[0];
                dpp_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[dpp_pkg::WIDTH_BITS-1:0];
                dpp_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[dpp_pkg::HEIGHT_BITS-1:0];
                default:                   ;
            endcase
        end
    end

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_accept  = in_valid && in_ready;

    dpp_raster_ctrl u_raster (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (in_accept),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .pos          (pos)
    );

    dpp_line_store u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_accept),
        .rd_addr (pos.col),
        .rd_data (above_data),
        .wr_en   (s1_advance),
        .wr_addr (s1_pos_reg.col),
        .wr_data (pixel)
    );

    always_comb
    begin
        if (s1_pos_reg.first_row)
        begin
            pred = s1_pos_reg.first_col ? '0 : left_reg;
        end
        else
        begin
            pred = s1_pos_reg.first_col ? above_data : above_left_reg;
        end
        if (direction_reg == dpp_pkg::DIR_FORWARD)
        begin
            pixel  = s1_sample_reg;
            result = s1_sample_reg - pred;
        end
        else
        begin
            pixel  = s1_sample_reg + pred;
            result = pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_sample_reg <= dpp_pkg::sample_t'(sample_value);
            s1_pos_reg    <= pos;
        end
        if (s1_advance)
        begin
            result_reg <= result;
            last_reg   <= s1_pos_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            left_reg       <= '0;
            above_left_reg <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                out_valid_reg  <= 1'b1;
                left_reg       <= pixel;
                above_left_reg <= above_data;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = signed'(result_reg);
    assign frame_last   = last_reg;

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("Accepted request did not enter the compute stage.");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid_reg)
        else $error("Computed result did not reach the output register.");

    a_same_column_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && s1_advance && (pos.col == s1_pos_reg.col) |=> above_data == $past(pixel))
        else $error("Line store read missed a write to the same column.");

endmodule

// ----- bench/tb_diagonal_pixel_predictor.sv -----
// Self-checking testbench for the diagonal pixel predictor with a predicting scoreboard.
module tb_diagonal_pixel_predictor;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   IDLE_LIMIT   = 1000;
    localparam int   RANDOM_ITEMS = 650;
    localparam int   STEADY_ITEMS = 100;
    localparam int   HOLD_CYCLES  = 40;
    localparam int   HOLD_PHASE   = 3;
    localparam int   HOLD_ITEMS   = 30;
    localparam logic DIR_REVERSE  = ~dpp_pkg::DIR_FORWARD;

    typedef struct {
        dpp_pkg::sample_t value;
        logic             last;
    } pixel_result_t;

    class dpcm_scoreboard;
        logic                            dir_mode;
        logic [dpp_pkg::WIDTH_BITS-1:0]  width_reg;
        logic [dpp_pkg::HEIGHT_BITS-1:0] height_reg;
        dpp_pkg::sample_t                line_store [dpp_pkg::MAX_WIDTH];
        dpp_pkg::sample_t                upper_left;
        dpp_pkg::sample_t                left_pixel;
        int unsigned                     col_pos;
        int unsigned                     row_pos;
        int unsigned                     filled;
        int unsigned                     mismatch_count;
        pixel_result_t                   pending [$];

        function new();
            dir_mode       = dpp_pkg::DIR_FORWARD;
            width_reg      = dpp_pkg::WIDTH_BITS'(dpp_pkg::MAX_WIDTH);
            height_reg     = dpp_pkg::HEIGHT_BITS'(1);
            upper_left     = '0;
            left_pixel     = '0;
            col_pos        = 0;
            row_pos        = 0;
            filled         = 0;
            mismatch_count = 0;
        endfunction

        function int unsigned width_of(logic [dpp_pkg::WIDTH_BITS-1:0] w);
            if (w == '0)
                return 1;
            if (w > dpp_pkg::MAX_WIDTH)
                return dpp_pkg::MAX_WIDTH;
            return 32'(w);
        endfunction

        function int unsigned active_width();
            return width_of(width_reg);
        endfunction

        function int unsigned active_height();
            return (height_reg == '0) ? 1 : 32'(height_reg);
        endfunction

        function void apply_register(dpp_pkg::cfg_reg_t index,
                                     logic [dpp_pkg::CFG_DATA_BITS-1:0] data);
            case (index)
                dpp_pkg::REG_DIRECTION:    dir_mode   = data[0];
                dpp_pkg::REG_FRAME_WIDTH:  width_reg  = data[dpp_pkg::WIDTH_BITS-1:0];
                dpp_pkg::REG_FRAME_HEIGHT: height_reg = data[dpp_pkg::HEIGHT_BITS-1:0];
                default: ;
            endcase
        endfunction

        // The prediction is the upper-left neighbor, with the left one in the first row
        // and the one above in the first column; the first pixel of the frame is predicted as zero.
        function void note_sample(dpp_pkg::sample_t sample);
            dpp_pkg::sample_t prediction;
            dpp_pkg::sample_t pixel;
            pixel_result_t    expected;
            logic             last_col;
            logic             last_row;
            if (row_pos == 0)
                prediction = (col_pos == 0) ? '0 : left_pixel;
            else
                prediction = (col_pos == 0) ? line_store[0] : upper_left;
            pixel = (dir_mode != dpp_pkg::DIR_FORWARD) ? sample + prediction : sample;
            expected.value = (dir_mode != dpp_pkg::DIR_FORWARD) ? pixel : sample - prediction;
            upper_left = line_store[col_pos];
            line_store[col_pos] = pixel;
            left_pixel = pixel;
            if (col_pos + 1 > filled)
                filled = col_pos + 1;
            last_col = (col_pos + 1 >= active_width());
            last_row = (row_pos + 1 >= active_height());
            expected.last = last_col && last_row;
            pending.push_back(expected);
            if (last_col)
            begin
                col_pos = 0;
                row_pos = last_row ? 0 : row_pos + 1;
            end
            else
                col_pos = col_pos + 1;
        endfunction

        task log_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            mismatch_count++;
        endtask

        task check_result(dpp_pkg::sample_t value, logic last);
            pixel_result_t expected;
            if (pending.size() == 0)
            begin
                log_mismatch($sformatf("result %h arrived with no request outstanding", value));
                return;
            end
            expected = pending.pop_front();
            if (value !== expected.value)
                log_mismatch($sformatf("result_value %h, predicted %h", value, expected.value));
            if (last !== expected.last)
                log_mismatch($sformatf("frame_last %b, predicted %b on result %h",
                                       last, expected.last, value));
        endtask
    endclass

    logic                                   clk          = 1'b0;
    logic                                   rst_n        = 1'b0;
    logic                                   cfg_valid    = 1'b0;
    logic                                   cfg_ready;
    logic [dpp_pkg::CFG_INDEX_BITS-1:0]     cfg_index    = '0;
    logic [dpp_pkg::CFG_DATA_BITS-1:0]      cfg_data     = '0;
    logic                                   in_valid     = 1'b0;
    logic                                   in_ready;
    logic signed [dpp_pkg::SAMPLE_BITS-1:0] sample_value = '0;
    logic                                   out_valid;
    logic                                   out_ready    = 1'b0;
    logic signed [dpp_pkg::SAMPLE_BITS-1:0] result_value;
    logic                                   frame_last;

    logic           hold_request = 1'b0;
    int             stall_odds   = 0;
    int             gap_odds     = 0;
    int             hold_left    = 0;
    int             stall_left   = 0;
    int             idle_cycles  = 0;
    dpcm_scoreboard dpcm;

    diagonal_pixel_predictor dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_value (sample_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .frame_last   (frame_last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                dpcm.apply_register(dpp_pkg::cfg_reg_t'(cfg_index), cfg_data);
            if (in_valid && in_ready)
                dpcm.note_sample(sample_value);
            if (out_valid && out_ready)
                dpcm.check_result(result_value, frame_last);
        end
    end

    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request <= 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
        begin
            stall_left = $urandom_range(1, 14) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic int pick_odds();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 3;
            2:       return 8;
            default: return 25;
        endcase
    endfunction

    task automatic send_sample(input dpp_pkg::sample_t value);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        sample_value <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic stop_samples();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_for_results();
        while (dpcm.pending.size() != 0)
            @(posedge clk);
    endtask

    // Settings change only with the block drained. A wider row is refused where it
    // would read line store entries that no earlier row has filled.
    task automatic program_registers(input bit [2:0] enable,
                                     input logic [dpp_pkg::CFG_DATA_BITS-1:0] dir_data,
                                     input logic [dpp_pkg::CFG_DATA_BITS-1:0] width_data,
                                     input logic [dpp_pkg::CFG_DATA_BITS-1:0] height_data);
        stop_samples();
        wait_for_results();
        if (enable[dpp_pkg::REG_FRAME_WIDTH] && dpcm.row_pos != 0 &&
            dpcm.width_of(width_data[dpp_pkg::WIDTH_BITS-1:0]) > dpcm.filled)
            enable[dpp_pkg::REG_FRAME_WIDTH] = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (enable[i])
            begin
                cfg_valid <= 1'b1;
                cfg_index <= dpp_pkg::cfg_reg_t'(i);
                case (dpp_pkg::cfg_reg_t'(i))
                    dpp_pkg::REG_DIRECTION:   cfg_data <= dir_data;
                    dpp_pkg::REG_FRAME_WIDTH: cfg_data <= width_data;
                    default:                  cfg_data <= height_data;
                endcase
                @(posedge clk);
                while (!cfg_ready)
                    @(posedge clk);
            end
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned                     sent;
        int unsigned                     count;
        int unsigned                     remaining;
        int unsigned                     phase;
        int unsigned                     w;
        int unsigned                     h;
        logic [dpp_pkg::WIDTH_BITS-1:0]  width_pick;
        logic [dpp_pkg::HEIGHT_BITS-1:0] height_pick;
        logic                            dir_pick;
        dpp_pkg::sample_t                base;
        dpp_pkg::sample_t                value;

        dpcm = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        gap_odds = 4;
        stall_odds <= 4;

        // Reset settings, then a row shrunk below the current column.
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'hFFFF);
        program_registers(3'b110, '0, 16'd3, 16'd2);
        send_sample(16'h1234);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h0000);

        program_registers(3'b001, {15'h0000, DIR_REVERSE}, '0, '0);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        send_sample(16'h8000);
        send_sample(16'h7FFF);

        // Zero width and height behave as one.
        program_registers(3'b110, '0, 16'h0000, 16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h8000);

        // Width above the line store size, tallest frame, then sizes cut mid-frame.
        program_registers(3'b111, {15'h7FFF, dpp_pkg::DIR_FORWARD}, 16'hFFFF, 16'hFFFF);
        send_sample(16'h0F0F);
        send_sample(16'hF0F0);
        send_sample(16'h5555);
        program_registers(3'b010, '0, 16'd2, '0);
        send_sample(16'hAAAA);
        send_sample(16'h0001);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'hFFFF);
        program_registers(3'b100, '0, '0, 16'd2);
        send_sample(16'h8001);
        send_sample(16'h7FFE);

        sent  = 0;
        phase = 0;
        base  = '0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= RANDOM_ITEMS - STEADY_ITEMS)
            begin
                gap_odds = 0;
                stall_odds <= 0;
            end
            else
            begin
                gap_odds = pick_odds();
                stall_odds <= pick_odds();
            end
            case ($urandom_range(0, 11))
                0:       width_pick = '0;
                1:       width_pick = dpp_pkg::WIDTH_BITS'(dpp_pkg::MAX_WIDTH);
                2:       width_pick = '1;
                3:       width_pick = dpp_pkg::WIDTH_BITS'($urandom_range(41, 8191));
                4, 5:    width_pick = dpp_pkg::WIDTH_BITS'($urandom_range(9, 40));
                default: width_pick = dpp_pkg::WIDTH_BITS'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 9))
                0:       height_pick = '0;
                1:       height_pick = '1;
                2:       height_pick = dpp_pkg::HEIGHT_BITS'($urandom);
                default: height_pick = dpp_pkg::HEIGHT_BITS'($urandom_range(1, 5));
            endcase
            dir_pick = $urandom_range(0, 1) ? DIR_REVERSE : dpp_pkg::DIR_FORWARD;
            program_registers(3'($urandom_range(0, 7)), {15'($urandom), dir_pick},
                              {3'($urandom), width_pick}, height_pick);

            if (phase == HOLD_PHASE)
            begin
                hold_request <= 1'b1;
                gap_odds = 0;
                count = HOLD_ITEMS;
            end
            else
            begin
                w = dpcm.active_width();
                h = dpcm.active_height();
                if (dpcm.col_pos >= w)
                    remaining = 1;
                else if (dpcm.row_pos >= h)
                    remaining = w - dpcm.col_pos;
                else
                    remaining = (h - dpcm.row_pos - 1) * w + (w - dpcm.col_pos);
                if (remaining <= 60 && $urandom_range(0, 3) != 0)
                    count = remaining;
                else
                    count = $urandom_range(1, 25);
            end

            repeat (count)
            begin
                case ($urandom_range(0, 9))
                    0:       value = 16'h8000;
                    1:       value = 16'h7FFF;
                    2:       value = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    3, 4, 5: value = 16'($urandom);
                    default: value = base + 16'($urandom_range(0, 15)) - 16'd8;
                endcase
                base = value;
                send_sample(value);
            end
            sent += count;
            phase++;
        end

        stop_samples();
        wait_for_results();
        repeat (8) @(posedge clk);
        if (dpcm.mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
